### rtl/core/inss_pkg.sv
// Package: shared constants and controller/datapath interface types for the insertion sorter.
`timescale 1ns / 1ps
`default_nettype none

package inss_pkg;

  localparam int unsigned CapacityDefault = 32;
  localparam int unsigned ValueWidth      = 32;

  typedef struct packed {
    logic insert;
    logic drain;
  } inss_cmd_t;

  typedef struct packed {
    logic last_one;
  } inss_status_t;

endpackage

`default_nettype wire

### rtl/core/inss_datapath.sv
// Datapath: row of compare-and-shift cells, fill count, overflow flag and output registers.
`timescale 1ns / 1ps
`default_nettype none

module inss_datapath #(
  parameter int unsigned CAPACITY = inss_pkg::CapacityDefault
) (
  input  wire                                       clk_i,
  input  wire                                       rst_ni,
  input  wire inss_pkg::inss_cmd_t                  cmd_i,
  output inss_pkg::inss_status_t                    status_o,
  input  wire logic signed [inss_pkg::ValueWidth-1:0] value_i,
  output logic signed [inss_pkg::ValueWidth-1:0]    value_res_o,
  output logic                                      last_res_o,
  output logic                                      overflow_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic signed [inss_pkg::ValueWidth-1:0] cell_q [CAPACITY];
  logic signed [inss_pkg::ValueWidth-1:0] cell_d [CAPACITY];
  logic [CAPACITY-1:0] gt;
  logic [CW-1:0]       count_q;
  logic                ovf_q;
  logic                full;

  assign full = (count_q == CW'(CAPACITY));
  assign status_o.last_one = (count_q == CW'(1));

  // each cell compares against the incoming value in parallel
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      gt[i] = (CW'(i) < count_q) && (cell_q[i] > value_i);
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_d[i] = cell_q[i];
      if (cmd_i.drain) begin
        if (i < CAPACITY - 1) begin
          cell_d[i] = cell_q[(i + 1) % CAPACITY];
        end
      end else if (cmd_i.insert && !full) begin
        if (gt[i] || (CW'(i) == count_q)) begin
          if (i > 0 && gt[(i + CAPACITY - 1) % CAPACITY]) begin
            cell_d[i] = cell_q[(i + CAPACITY - 1) % CAPACITY];
          end else begin
            cell_d[i] = value_i;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_q[i] <= cell_d[i];
    end
    if (cmd_i.drain) begin
      value_res_o <= cell_q[0];
      last_res_o  <= status_o.last_one;
      overflow_o  <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (cmd_i.drain) begin
      count_q <= count_q - CW'(1);
      if (status_o.last_one) begin
        ovf_q <= 1'b0;
      end
    end else if (cmd_i.insert) begin
      if (full) begin
        ovf_q <= 1'b1;
      end else begin
        count_q <= count_q + CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/inss_ctrl.sv
// Controller: fill/drain state machine and the handshakes of both channels.
`timescale 1ns / 1ps
`default_nettype none

module inss_ctrl (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_stall_o,
  input  wire                    last_i,
  output logic                   out_valid_o,
  input  wire                    out_stall_i,
  output inss_pkg::inss_cmd_t    cmd_o,
  input  wire inss_pkg::inss_status_t status_i
);

  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } state_e;

  state_e state_q;
  logic   in_xfer;
  logic   out_free;

  assign in_stall_o   = (state_q != ST_FILL);
  assign in_xfer      = in_valid_i && !in_stall_o;
  assign out_free     = !out_valid_o || !out_stall_i;
  assign cmd_o.insert = in_xfer;
  assign cmd_o.drain  = (state_q == ST_DRAIN) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FILL;
      out_valid_o <= 1'b0;
    end else begin
      case (state_q)
        ST_FILL: begin
          if (!out_stall_i) begin
            out_valid_o <= 1'b0;
          end
          if (in_xfer && last_i) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (out_free) begin
            out_valid_o <= 1'b1;
            if (status_i.last_one) begin
              state_q <= ST_FILL;
            end
          end
        end
        default: begin
          state_q     <= ST_FILL;
          out_valid_o <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/insertion_sorter_core.sv
// Insertion sorter: streaming ascending sort of signed 32-bit values, one list at a time.
//
// Input channel (in_valid_i / in_stall_o, value_i, last_i): one value per transfer.
// Each value is inserted into a row of CAPACITY compare-and-shift cells in the
// cycle of its transfer, so values are taken one per cycle while the input is
// not stalled. Equal values keep arrival order. Values beyond CAPACITY are
// dropped and flag the list. The transfer carrying last_i ends the list; the
// input then stalls while the list drains.
// Output channel (out_valid_o / out_stall_i, value_res_o, last_res_o, overflow_o):
// the sorted list leaves in ascending order, one result per cycle while the
// receiver does not stall; the first follows once the controller has entered
// its drain state and the result is registered. last_res_o marks the final result
// and overflow_o is set on every result of a list that lost values. The cell row
// is emptied and input reopens at the edge that registers the final result.
// A stall holds the output register and pauses the drain.
// Reset empties the list and clears the overflow flag and the output valid;
// the cells are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module insertion_sorter_core #(
  parameter int unsigned CAPACITY = inss_pkg::CapacityDefault
) (
  input  wire                                         clk_i,
  input  wire                                         rst_ni,
  input  wire                                         in_valid_i,
  output logic                                        in_stall_o,
  input  wire logic signed [inss_pkg::ValueWidth-1:0] value_i,
  input  wire                                         last_i,
  output logic                                        out_valid_o,
  input  wire                                         out_stall_i,
  output logic signed [inss_pkg::ValueWidth-1:0]      value_res_o,
  output logic                                        last_res_o,
  output logic                                        overflow_o
);

  inss_pkg::inss_cmd_t    cmd;
  inss_pkg::inss_status_t status;

  inss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  inss_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .value_i     (value_i),
    .value_res_o (value_res_o),
    .last_res_o  (last_res_o),
    .overflow_o  (overflow_o)
  );

endmodule

`default_nettype wire

### tb/tb.sv
// Testbench for insertion_sorter_core: lists in, ascending sorted lists out, with overflow checks.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned Cap = inss_pkg::CapacityDefault;
  localparam int unsigned W   = inss_pkg::ValueWidth;

  typedef struct {
    logic signed [W-1:0] value;
    logic                last;
    bit                  wait_drain;
  } elem_t;

  typedef struct {
    logic signed [W-1:0] value;
    logic                last;
    logic                overflow;
  } sorted_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic signed [W-1:0] value_i     = '0;
  logic                last_i      = 1'b0;
  logic                out_stall_i = 1'b0;
  logic                in_stall_o;
  logic                out_valid_o;
  logic signed [W-1:0] value_res_o;
  logic                last_res_o;
  logic                overflow_o;

  elem_t               elem_q[$];
  sorted_t             sorted_q[$];
  logic signed [W-1:0] sort_row[Cap];
  int unsigned         row_fill = 0;
  bit                  row_ovf  = 1'b0;
  int unsigned         n_taken  = 0;
  int unsigned         n_sorted = 0;
  int unsigned         n_fail   = 0;
  int unsigned         holdoff_left = 0;
  bit                  holdoff_done = 1'b0;
  int unsigned         send_idle_pct;
  int unsigned         recv_idle_pct;
  sorted_t             got_want;

  insertion_sorter_core #(.CAPACITY(Cap)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_res_o (value_res_o),
    .last_res_o  (last_res_o),
    .overflow_o  (overflow_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #4_000_000;
    $display("[insertion_sorter_core] ERROR");
    $finish;
  end

  // idling pattern moves on with the number of transfers taken
  always_comb begin
    if (n_taken < 120) begin
      send_idle_pct = 34;
      recv_idle_pct = 50;
    end else if (n_taken < 240) begin
      send_idle_pct = 50;
      recv_idle_pct = 34;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  end

  function automatic void sort_insert(input elem_t e);
    int unsigned pos;
    sorted_t     r;
    if (row_fill >= Cap) begin
      row_ovf = 1'b1;
    end else begin
      pos = row_fill;
      while (pos > 0 && sort_row[pos-1] > e.value) begin
        sort_row[pos] = sort_row[pos-1];
        pos--;
      end
      sort_row[pos] = e.value;
      row_fill++;
    end
    if (e.last) begin
      for (int unsigned k = 0; k < row_fill; k++) begin
        r.value    = sort_row[k];
        r.last     = (k + 1 == row_fill);
        r.overflow = row_ovf;
        sorted_q   = {sorted_q, r};
      end
      row_fill = 0;
      row_ovf  = 1'b0;
    end
  endfunction

  function automatic logic signed [W-1:0] pick_value();
    case ($urandom_range(9))
      5, 6, 7: pick_value = $signed($urandom_range(20)) - 10;
      8:       pick_value = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      9:       pick_value = $urandom_range(1) ? 32'sh7ffffff0 + $urandom_range(15)
                                              : 32'sh80000000 + $urandom_range(15);
      default: pick_value = $urandom;
    endcase
  endfunction

  function automatic void push_elem(input logic signed [W-1:0] v, input logic l,
                                    input bit wd = 1'b0);
    elem_t e;
    e.value      = v;
    e.last       = l;
    e.wait_drain = wd;
    elem_q       = {elem_q, e};
  endfunction

  function automatic void add_list(input int unsigned len, input bit wd);
    for (int unsigned i = 0; i < len; i++)
      push_elem(pick_value(), i + 1 == len, wd && i == 0);
  endfunction

  // sender
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        sort_insert(elem_q.pop_front());
        n_taken++;
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (elem_q.size() > 0 && !(elem_q[0].wait_drain && sorted_q.size() > 0) &&
            $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          value_i    <= elem_q[0].value;
          last_i     <= elem_q[0].last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (holdoff_left > 0) begin
        holdoff_left <= holdoff_left - 1;
      end else if (!holdoff_done && n_sorted >= 40) begin
        holdoff_done <= 1'b1;
        holdoff_left <= 150;
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        n_sorted <= n_sorted + 1;
        if (sorted_q.size() == 0) begin
          $error("unexpected transfer: value_res_o %0d last_res_o %0b overflow_o %0b",
                 value_res_o, last_res_o, overflow_o);
          n_fail++;
        end else begin
          got_want = sorted_q.pop_front();
          if (value_res_o !== got_want.value) begin
            $error("value_res_o expected %0d got %0d", got_want.value, value_res_o);
            n_fail++;
          end
          if (last_res_o !== got_want.last) begin
            $error("last_res_o expected %0b got %0b", got_want.last, last_res_o);
            n_fail++;
          end
          if (overflow_o !== got_want.overflow) begin
            $error("overflow_o expected %0b got %0b", got_want.overflow, overflow_o);
            n_fail++;
          end
        end
      end
      if (holdoff_left > 0) begin
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  initial begin
    int unsigned n_rand;
    int unsigned len;
    int unsigned n_list;
    n_rand = 0;
    n_list = 0;

    push_elem(32'sh7fffffff, 1'b1);
    push_elem(32'sh80000000, 1'b1);
    push_elem(0, 1'b0);
    push_elem(-1, 1'b0);
    push_elem(1, 1'b0);
    push_elem(32'sh7fffffff, 1'b0);
    push_elem(32'sh80000000, 1'b0);
    push_elem(5, 1'b0);
    push_elem(5, 1'b0);
    push_elem(-1, 1'b1);
    push_elem(100, 1'b0);
    push_elem(50, 1'b0);
    push_elem(0, 1'b0);
    push_elem(-50, 1'b0);
    push_elem(-100, 1'b1);
    push_elem(7, 1'b0);
    push_elem(7, 1'b0);
    push_elem(7, 1'b1);
    push_elem(32'sh55555555, 1'b0);
    push_elem(32'shaaaaaaaa, 1'b0);
    push_elem(32'sh80000001, 1'b0);
    push_elem(32'sh7ffffffe, 1'b1);

    // full row, last one dropped, several dropped
    add_list(Cap, 1'b1);
    add_list(Cap + 1, 1'b0);
    add_list(Cap + 4, 1'b0);
    n_rand = elem_q.size();
    while (n_rand < 320) begin
      case ($urandom_range(19)) inside
        [0:13]:  len = $urandom_range(12, 1);
        [14:17]: len = $urandom_range(Cap + 2, Cap - 2);
        default: len = $urandom_range(Cap + 10, Cap + 3);
      endcase
      add_list(len, n_list % 6 == 5);
      n_rand += len;
      n_list++;
    end

    while (elem_q.size() != 0 || sorted_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (n_fail == 0 && sorted_q.size() == 0) begin
      $display("[insertion_sorter_core] OK");
    end else begin
      $display("[insertion_sorter_core] ERROR");
    end
    $finish;
  end

endmodule
